/* rtl/sorted_descending_priority_queue_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sorted descending priority queue unit
// Concurrent checks clocked by i_clk, off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_DESCENDING_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_DESCENDING_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define SDPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sdpq assertion failed");

// next-cycle implication
`define SDPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sdpq assertion failed");

`endif

/* rtl/sdpq_pkg.sv */
// ---------------------------------------------------------------------------
// sdpq_pkg
// Command and status codes and the cell control group of the queue.
// ---------------------------------------------------------------------------
package sdpq_pkg;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;
    localparam int IO_BITS     = 32;

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DRAIN  = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic do_insert;
        logic do_pop;
    } t_cell_ctrl;

endpackage

/* rtl/sdpq_cell.sv */
// ---------------------------------------------------------------------------
// sdpq_cell
// One slot of the sorted chain: compares the broadcast insert value with
// its own entry, shifts toward the tail on insert and toward the head on pop.
// ---------------------------------------------------------------------------
module sdpq_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    i_clk,
    input  sdpq_pkg::t_cell_ctrl    i_ctrl,
    input  logic [VALUE_BITS-1:0]   i_ins,
    input  logic                    i_occ,
    input  logic [VALUE_BITS-1:0]   i_left_val,
    input  logic                    i_left_gt,
    input  logic [VALUE_BITS-1:0]   i_right_val,
    output logic [VALUE_BITS-1:0]   o_val,
    output logic                    o_gt
);
    import sdpq_pkg::*;

    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] n_val;

    assign o_gt  = !i_occ || ($signed(i_ins) > $signed(r_val));
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.do_insert && o_gt) begin
            n_val = i_left_gt ? i_left_val : i_ins;
        end else if (i_ctrl.do_pop) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* rtl/sorted_descending_priority_queue_unit.sv */
// ---------------------------------------------------------------------------
// sorted_descending_priority_queue_unit
// Bounded priority queue held as a chain of sorted cells, largest at the
// head; inserts keep ties in arrival order, remove and drain pop the head.
//
//   beat     direction  handshake           payload
//   command  in         start && !busy      i_cmd, i_value
//   result   out        o_strobe (1 cycle)  o_out_value, o_status, o_last,
//                                           o_count, o_is_empty
//
// Insert and remove results show the cycle after the beat and busy stays
// low, so a command may enter every cycle.
// Drain of N values gives N results back to back; busy stays high while
// pops remain after the beat, set by the one-pop-per-cycle chain shift.
// Reset clears the fill count and the control flags; cell contents are
// not reset. The receiver cannot stall results.
// ---------------------------------------------------------------------------
module sorted_descending_priority_queue_unit #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sdpq_pkg::CMD_BITS-1:0]      i_cmd,
    input  logic signed [sdpq_pkg::IO_BITS-1:0] i_value,
    output logic                               o_strobe,
    output logic signed [sdpq_pkg::IO_BITS-1:0] o_out_value,
    output logic [sdpq_pkg::STATUS_BITS-1:0]   o_status,
    output logic                               o_last,
    output logic [$clog2(CAPACITY+1)-1:0]      o_count,
    output logic                               o_is_empty
);
    import sdpq_pkg::*;

`include "sorted_descending_priority_queue_unit_assert.svh"

    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int EXT_BITS   = (VALUE_BITS > IO_BITS) ? VALUE_BITS : IO_BITS;
    localparam logic [COUNT_BITS-1:0] FILL_MAX = COUNT_BITS'(CAPACITY);
    localparam logic [COUNT_BITS-1:0] FILL_ONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] r_fill, n_fill;
    logic                  r_busy, n_busy;
    logic                  r_strobe, n_strobe;
    logic [IO_BITS-1:0]    r_out_value, n_out_value;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic                  r_last, n_last;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_is_empty;

    logic                  accept;
    logic                  fill_zero;
    logic                  fill_full;
    logic [EXT_BITS-1:0]   ins_ext;
    logic [VALUE_BITS-1:0] ins;
    logic [EXT_BITS-1:0]   head_ext;
    t_cell_ctrl            ctrl;

    logic [VALUE_BITS-1:0] w_val       [CAPACITY];
    logic                  w_gt        [CAPACITY];
    logic                  w_occ       [CAPACITY];
    logic [VALUE_BITS-1:0] w_left_val  [CAPACITY];
    logic                  w_left_gt   [CAPACITY];
    logic [VALUE_BITS-1:0] w_right_val [CAPACITY];

    assign accept    = start && !r_busy;
    assign fill_zero = (r_fill == '0);
    assign fill_full = (r_fill == FILL_MAX);
    assign ins_ext   = EXT_BITS'(i_value);
    assign ins       = ins_ext[VALUE_BITS-1:0];
    assign head_ext  = EXT_BITS'(w_val[0]);

    assign ctrl.do_insert = accept && (i_cmd == CMD_INSERT) && !fill_full;
    assign ctrl.do_pop    = r_busy || (accept && !fill_zero &&
                            ((i_cmd == CMD_REMOVE) || (i_cmd == CMD_DRAIN)));

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_occ[i]       = (COUNT_BITS'(i) < r_fill);
            w_left_val[i]  = (i == 0) ? ins : w_val[(i == 0) ? 0 : i - 1];
            w_left_gt[i]   = (i == 0) ? 1'b0 : w_gt[(i == 0) ? 0 : i - 1];
            w_right_val[i] = (i == CAPACITY - 1) ? w_val[i]
                           : w_val[(i == CAPACITY - 1) ? i : i + 1];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sdpq_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_ins       (ins),
            .i_occ       (w_occ[g]),
            .i_left_val  (w_left_val[g]),
            .i_left_gt   (w_left_gt[g]),
            .i_right_val (w_right_val[g]),
            .o_val       (w_val[g]),
            .o_gt        (w_gt[g])
        );
    end

    always_comb begin
        n_fill      = r_fill;
        n_busy      = 1'b0;
        n_strobe    = 1'b0;
        n_out_value = '0;
        n_status    = STATUS_OK;
        n_last      = 1'b1;
        if (ctrl.do_pop) begin
            n_fill      = r_fill - FILL_ONE;
            n_strobe    = 1'b1;
            n_out_value = head_ext[IO_BITS-1:0];
            if (r_busy || (i_cmd == CMD_DRAIN)) begin
                n_last = (r_fill == FILL_ONE);
                n_busy = (r_fill != FILL_ONE);
            end
        end else if (accept) begin
            unique case (i_cmd)
                CMD_INSERT: begin
                    n_strobe = 1'b1;
                    if (fill_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        n_fill = r_fill + FILL_ONE;
                    end
                end
                CMD_REMOVE, CMD_DRAIN: begin
                    n_strobe = 1'b1;
                    n_status = STATUS_EMPTY;
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_status    <= n_status;
        r_last      <= n_last;
        r_count     <= n_fill;
        r_is_empty  <= (n_fill == '0);
    end

    assign busy        = r_busy;
    assign o_strobe    = r_strobe;
    assign o_out_value = r_out_value;
    assign o_status    = r_status;
    assign o_last      = r_last;
    assign o_count     = r_count;
    assign o_is_empty  = r_is_empty;

    `SDPQ_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FILL_MAX)
    `SDPQ_ASSERT_SAME(a_busy_nonempty, r_busy, !fill_zero)
    `SDPQ_ASSERT_SAME(a_full_count, o_strobe && (o_status == STATUS_FULL), o_count == FILL_MAX)
    `SDPQ_ASSERT_NEXT(a_remove_count,
        accept && (i_cmd == CMD_REMOVE) && !fill_zero,
        o_strobe && (o_count == COUNT_BITS'($past(r_fill) - FILL_ONE)))
    `SDPQ_ASSERT_SAME(a_head_order, (r_fill >= COUNT_BITS'(2)) && !r_busy,
        !($signed(w_val[1]) > $signed(w_val[0])))

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for sorted_descending_priority_queue_unit
// Drives insert, remove and drain commands over the start/busy handshake and
// predicts every result beat with a behavioral sorted list of the same size.
// Each strobed result is checked field by field against the oldest prediction.
// Covers empty and full stores, the value extremes, ties, the unused command,
// and random traffic with several sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sdpq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [IO_BITS-1:0] out_value;
        logic [STATUS_BITS-1:0]    status;
        logic                      last;
        logic [CNT_BITS-1:0]       count;
        logic                      is_empty;
    } queue_result_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [CMD_BITS-1:0]        i_cmd = CMD_INSERT;
    logic signed [IO_BITS-1:0]  i_value = '0;
    logic                       o_strobe;
    logic signed [IO_BITS-1:0]  o_out_value;
    logic [STATUS_BITS-1:0]     o_status;
    logic                       o_last;
    logic [CNT_BITS-1:0]        o_count;
    logic                       o_is_empty;

    logic signed [IO_BITS-1:0]  held_values [CAPACITY];
    int unsigned                held_count = 0;
    queue_result_t              pending_results [$];
    int unsigned                error_count = 0;
    int unsigned                cycle_count = 0;
    int unsigned                sender_idle_pct = 0;

    sorted_descending_priority_queue_unit #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (IO_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_out_value (o_out_value),
        .o_status    (o_status),
        .o_last      (o_last),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void queue_result(input logic signed [IO_BITS-1:0] value,
                                         input logic [STATUS_BITS-1:0] status,
                                         input logic last);
        queue_result_t r;
        r.out_value = value;
        r.status    = status;
        r.last      = last;
        r.count     = held_count[CNT_BITS-1:0];
        r.is_empty  = (held_count == 0);
        pending_results.push_back(r);
    endfunction

    function automatic logic signed [IO_BITS-1:0] pop_largest();
        logic signed [IO_BITS-1:0] head;
        head = held_values[0];
        for (int i = 1; i < held_count; i++)
            held_values[i-1] = held_values[i];
        held_count--;
        return head;
    endfunction

    function automatic void predict_queue_op(input logic [CMD_BITS-1:0] cmd,
                                             input logic signed [IO_BITS-1:0] value);
        int unsigned pos;
        logic signed [IO_BITS-1:0] popped;
        case (cmd)
            CMD_INSERT: begin
                if (held_count >= CAPACITY) begin
                    queue_result('0, STATUS_FULL, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < held_count && !(value > held_values[pos]))
                        pos++;
                    for (int i = held_count; i > pos; i--)
                        held_values[i] = held_values[i-1];
                    held_values[pos] = value;
                    held_count++;
                    queue_result('0, STATUS_OK, 1'b1);
                end
            end
            CMD_REMOVE: begin
                if (held_count == 0) begin
                    queue_result('0, STATUS_EMPTY, 1'b1);
                end else begin
                    popped = pop_largest();
                    queue_result(popped, STATUS_OK, 1'b1);
                end
            end
            CMD_DRAIN: begin
                if (held_count == 0) begin
                    queue_result('0, STATUS_EMPTY, 1'b1);
                end else begin
                    while (held_count > 0) begin
                        popped = pop_largest();
                        queue_result(popped, STATUS_OK, held_count == 0);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        queue_result_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, out_value %0d status %0d",
                         $time, o_out_value, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_value !== want.out_value) begin
                    $display("%0t: out_value expected %0d actual %0d",
                             $time, want.out_value, o_out_value);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d",
                             $time, want.last, o_last);
                    error_count++;
                end
                if (o_count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, o_count);
                    error_count++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $display("%0t: is_empty expected %0d actual %0d",
                             $time, want.is_empty, o_is_empty);
                    error_count++;
                end
            end
        end
    end

    task automatic send_beat(input logic [CMD_BITS-1:0] cmd,
                             input logic signed [IO_BITS-1:0] value);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        predict_queue_op(cmd, value);
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [IO_BITS-1:0] pick_value();
        int unsigned mode;
        mode = $urandom_range(99);
        if (mode < 30)
            return $signed($urandom_range(6)) - 3;
        if (mode < 40) begin
            case ($urandom_range(3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_empty_store();
        send_beat(CMD_REMOVE, 32'sd0);
        send_beat(CMD_DRAIN, -32'sd1);
        send_beat(CMD_UNUSED, 32'sh7FFF_FFFF);
        wait_until_drained();
    endtask

    task automatic test_fill_to_capacity();
        send_beat(CMD_INSERT, 32'sh7FFF_FFFF);
        send_beat(CMD_INSERT, 32'sh8000_0000);
        send_beat(CMD_INSERT, 32'sd0);
        send_beat(CMD_INSERT, -32'sd1);
        for (int i = 4; i < CAPACITY; i++)
            send_beat(CMD_INSERT, $signed($urandom_range(4)) - 2);
        send_beat(CMD_INSERT, 32'sd5);
        send_beat(CMD_REMOVE, 32'sd0);
        send_beat(CMD_DRAIN, 32'sd0);
        wait_until_drained();
    endtask

    task automatic test_random_traffic(input int unsigned beats, input int unsigned idle_pct);
        int unsigned sent;
        int unsigned pick;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < beats) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                for (int i = 0; i < CAPACITY + 2; i++)
                    send_beat(CMD_INSERT, pick_value());
                sent += CAPACITY + 2;
            end else if (pick < 58) begin
                send_beat(CMD_INSERT, pick_value());
                sent++;
            end else if (pick < 86) begin
                send_beat(CMD_REMOVE, $urandom);
                sent++;
            end else if (pick < 95) begin
                send_beat(CMD_DRAIN, $urandom);
                sent++;
            end else begin
                send_beat(CMD_UNUSED, $urandom);
            end
        end
        wait_until_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_fill_to_capacity();
        test_random_traffic(90, 0);
        test_random_traffic(80, 50);
        test_random_traffic(80, 22);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
